// File: design/ple_pkg.sv
// shared types, codes and widths of the positional list engine
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   // configuration limits
   localparam int DEPTH_DEFAULT = 16;
   localparam int DEPTH_MAX     = 64;

   // transaction field widths
   localparam int OPCODE_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 8;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 7;
   localparam int COUNT_W    = 7;

   // position compares run one bit wider than the position field
   localparam int CMP_W = POSITION_W + 1;

   // slot numbers inside the cell chain, wide enough for the largest chain
   localparam int SLOT_W = $clog2(DEPTH_MAX);

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_INS_FIRST = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_LAST  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DEL_FIRST = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DEL_LAST  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_DUMP      = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   // what every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_mode_type;

   // control broadcast along the chain
   typedef struct packed {
      cell_mode_type     mode;
      logic [SLOT_W-1:0] slot;   // edit slot, zero-based
      logic [SLOT_W-1:0] tail;   // slot of the last held element
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: design/ple_if.sv
// request and response channel interfaces of the positional list engine
`timescale 1ns / 1ps
`default_nettype none

interface ple_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [ple_pkg::OPCODE_W-1:0]    opcode;
   logic signed [ple_pkg::VALUE_W-1:0]     value;
   logic        [ple_pkg::POSITION_W-1:0]  position;

   modport source (output valid, output opcode, output value, output position, input ready);
   modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface ple_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [ple_pkg::STATUS_W-1:0]   status;
   logic signed [ple_pkg::VALUE_W-1:0]    element;
   logic        [ple_pkg::INDEX_W-1:0]    element_index;
   logic        [ple_pkg::COUNT_W-1:0]    item_count;
   logic                                  last;

   modport source (output valid, output status, output element, output element_index,
                   output item_count, output last, input ready);
   modport sink   (input valid, input status, input element, input element_index,
                   input item_count, input last, output ready);
endinterface

`default_nettype wire

// File: design/ple_cell.sv
// one storage cell of the list chain
`timescale 1ns / 1ps
`default_nettype none

module ple_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                                 clock,
   input  wire ple_pkg::cell_ctrl_type               ctrl,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]   new_value,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]   left_value,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]   right_value,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]   head_value,
   output      logic signed [ple_pkg::VALUE_W-1:0]   data
);

   localparam logic [ple_pkg::SLOT_W-1:0] MY_SLOT = ple_pkg::SLOT_W'(INDEX);

   logic signed [ple_pkg::VALUE_W-1:0] data_ff;
   logic signed [ple_pkg::VALUE_W-1:0] data_in;

   always_comb begin
      unique case (ctrl.mode)
         ple_pkg::CELL_HOLD: begin
            data_in = data_ff;
         end
         ple_pkg::CELL_INSERT: begin
            if (MY_SLOT > ctrl.slot) begin
               data_in = left_value;
            end else if (MY_SLOT == ctrl.slot) begin
               data_in = new_value;
            end else begin
               data_in = data_ff;
            end
         end
         ple_pkg::CELL_DELETE: begin
            // cells at and above the slot close the gap
            data_in = (MY_SLOT >= ctrl.slot) ? right_value : data_ff;
         end
         ple_pkg::CELL_ROTATE: begin
            data_in = (MY_SLOT == ctrl.tail) ? head_value : right_value;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// File: design/positional_list_engine.sv
// top level of the positional list engine: command decode, cell chain, response register
// an edit's single result is registered and shown in the cycle after its request transaction
// throughput: one edit per cycle while the response side takes transactions
// dump of n elements: n results, one per rotation of the cell chain, which moves one element to
//    its head each cycle while the response side takes transactions; next request after the last
// reset (synchronous, active high) empties the list and clears the response valid bit
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine #(
   parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   ple_req_if.sink     req_chan,
   ple_rsp_if.source   rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   // control registers
   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] dump_idx_ff, dump_idx_in;

   // response register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic        [ple_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic signed [ple_pkg::VALUE_W-1:0]    rsp_element_ff, rsp_element_in;
   logic        [ple_pkg::INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic        [ple_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                                  rsp_last_ff, rsp_last_in;

   // handshake
   logic out_free;
   logic req_fire;
   logic dump_step;
   logic dump_last;

   // decode of the incoming command
   logic                                edit_start_dump;
   logic [ple_pkg::STATUS_W-1:0]        edit_status;
   logic [CNT_W-1:0]                    edit_count;
   ple_pkg::cell_ctrl_type              edit_ctrl;
   ple_pkg::cell_ctrl_type              chain_ctrl;
   logic                                is_full;
   logic                                is_empty;
   logic [ple_pkg::CMP_W-1:0]           pos_wide;
   logic [ple_pkg::CMP_W-1:0]           count_wide;
   logic [ple_pkg::SLOT_W-1:0]          pos_slot;
   logic [ple_pkg::SLOT_W-1:0]          tail_slot;

   // cell chain outputs
   logic signed [ple_pkg::VALUE_W-1:0] cell_q [DEPTH];

   // the output register frees up when empty or being taken
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign dump_step = (state_ff == ST_DUMP) && out_free;
   assign dump_last = (CNT_W'(dump_idx_ff) + CNT_W'(1)) == count_ff;

   assign is_full    = count_ff == CNT_W'(DEPTH);
   assign is_empty   = count_ff == '0;
   assign pos_wide   = ple_pkg::CMP_W'(req_chan.position);
   assign count_wide = ple_pkg::CMP_W'(count_ff);
   // position minus one; only used once the position is known to be in range
   assign pos_slot   = ple_pkg::SLOT_W'(req_chan.position - ple_pkg::POSITION_W'(1));
   // gives the top slot when the chain is full, which is what a full rotate needs
   assign tail_slot  = ple_pkg::SLOT_W'(count_ff) - ple_pkg::SLOT_W'(1);

   // command decode
   always_comb begin
      edit_start_dump = 1'b0;
      edit_status     = ple_pkg::STATUS_OK;
      edit_count      = count_ff;
      edit_ctrl.mode  = ple_pkg::CELL_HOLD;
      edit_ctrl.slot  = '0;
      edit_ctrl.tail  = tail_slot;
      unique case (req_chan.opcode)
         ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST: begin
            if (is_full) begin
               edit_status = ple_pkg::STATUS_FULL;
            end else begin
               edit_ctrl.mode = ple_pkg::CELL_INSERT;
               edit_ctrl.slot = (req_chan.opcode == ple_pkg::OP_INS_FIRST)
                              ? '0 : ple_pkg::SLOT_W'(count_ff);
               edit_count     = count_ff + CNT_W'(1);
            end
         end
         ple_pkg::OP_INS_AT: begin
            // range check ranks above the full check
            if (pos_wide == '0 || pos_wide > count_wide + ple_pkg::CMP_W'(1)) begin
               edit_status = ple_pkg::STATUS_BADPOS;
            end else if (is_full) begin
               edit_status = ple_pkg::STATUS_FULL;
            end else begin
               edit_ctrl.mode = ple_pkg::CELL_INSERT;
               edit_ctrl.slot = pos_slot;
               edit_count     = count_ff + CNT_W'(1);
            end
         end
         ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST: begin
            if (is_empty) begin
               edit_status = ple_pkg::STATUS_EMPTY;
            end else begin
               edit_ctrl.mode = ple_pkg::CELL_DELETE;
               edit_ctrl.slot = (req_chan.opcode == ple_pkg::OP_DEL_FIRST) ? '0 : tail_slot;
               edit_count     = count_ff - CNT_W'(1);
            end
         end
         ple_pkg::OP_DEL_AT: begin
            // also covers a positional delete on an empty list
            if (pos_wide == '0 || pos_wide > count_wide) begin
               edit_status = ple_pkg::STATUS_BADPOS;
            end else begin
               edit_ctrl.mode = ple_pkg::CELL_DELETE;
               edit_ctrl.slot = pos_slot;
               edit_count     = count_ff - CNT_W'(1);
            end
         end
         ple_pkg::OP_DUMP: begin
            if (is_empty) begin
               edit_status = ple_pkg::STATUS_EMPTY;
            end else begin
               edit_start_dump = 1'b1;
            end
         end
         default: begin
            // unused opcode: plain ok result, nothing changes
            edit_status = ple_pkg::STATUS_OK;
         end
      endcase
   end

   // chain control: edits on an accepted transaction, rotation on each dump step
   always_comb begin
      chain_ctrl.mode = ple_pkg::CELL_HOLD;
      chain_ctrl.slot = edit_ctrl.slot;
      chain_ctrl.tail = tail_slot;
      if (req_fire) begin
         chain_ctrl.mode = edit_ctrl.mode;
      end else if (dump_step) begin
         chain_ctrl.mode = ple_pkg::CELL_ROTATE;
      end
   end

   // the cell chain; cell 0 is the head of the list
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      ple_cell #(
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .ctrl        (chain_ctrl),
         .new_value   (req_chan.value),
         .left_value  ((g == 0) ? req_chan.value : cell_q[(g == 0) ? 0 : g - 1]),
         .right_value ((g == DEPTH - 1) ? cell_q[0] : cell_q[(g == DEPTH - 1) ? 0 : g + 1]),
         .head_value  (cell_q[0]),
         .data        (cell_q[g])
      );
   end

   // sequencer, count and response register next values
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      if (req_fire) begin
         count_in = edit_count;
         if (edit_start_dump) begin
            // first dump result follows from the chain head next cycle
            state_in    = ST_DUMP;
            dump_idx_in = '0;
         end else begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = edit_status;
            rsp_element_in = '0;
            rsp_index_in   = '0;
            rsp_count_in   = ple_pkg::COUNT_W'(edit_count);
            rsp_last_in    = 1'b1;
         end
      end else if (dump_step) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = ple_pkg::STATUS_OK;
         rsp_element_in = cell_q[0];
         rsp_index_in   = ple_pkg::INDEX_W'(dump_idx_ff) + ple_pkg::INDEX_W'(1);
         rsp_count_in   = ple_pkg::COUNT_W'(count_ff);
         rsp_last_in    = dump_last;
         if (dump_last) begin
            state_in = ST_IDLE;
         end else begin
            dump_idx_in = dump_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.element       = rsp_element_ff;
   assign rsp_chan.element_index = rsp_index_ff;
   assign rsp_chan.item_count    = rsp_count_ff;
   assign rsp_chan.last          = rsp_last_ff;

   // the count never passes the chain length
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count above depth");

   // a dump leaves the count alone
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |=> $stable(count_ff))
      else $error("count changed during dump");

   // the final dump result carries the index equal to the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && rsp_index_ff != '0 |-> rsp_index_ff == rsp_count_ff)
      else $error("last dump result index does not match count");

   // results that are not dump elements carry a zero element and have last set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_index_ff == '0 |-> rsp_element_ff == '0 && rsp_last_ff)
      else $error("non-dump result with element or without last");

endmodule

`default_nettype wire
